// File: sv/rbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the resource barrier planner
// Register indexes, reset values, field widths and the table entry layout.
// ----------------------------------------------------------------------------
package rbp_pkg;

  // Field widths fixed by the access and result formats
  localparam int unsigned PassW   = 8;
  localparam int unsigned ResW    = 8;
  localparam int unsigned StageW  = 16;
  localparam int unsigned AccessW = 32;
  localparam int unsigned LayoutW = 4;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegUndefLayout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTopOfPipe   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNoAccess    = 2'd2;

  localparam logic [LayoutW-1:0] UndefLayoutRst = 4'd0;
  localparam logic [StageW-1:0]  TopOfPipeRst   = 16'd1;
  localparam logic [AccessW-1:0] NoAccessRst    = 32'd0;

  localparam int unsigned DefMaxResources = 256;

  // One entry of the last-access table (53 bits)
  typedef struct packed {
    logic               wr;
    logic [StageW-1:0]  stage;
    logic [AccessW-1:0] access;
    logic [LayoutW-1:0] layout;
  } entry_t;

endpackage

// File: sv/resource_barrier_planner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_barrier_planner_top: hazard tracker with barrier insertion
// Answers each resource access with one result that says whether a barrier
// must precede it, using a per-resource table of the last access.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one access per beat in
//   execution order. Output channel (out_valid / out_stall) gives exactly
//   one result beat per access, in the same order.
//   Config channel (cfg_valid / cfg_ready) is always ready; write the three
//   source codes only while the block is idle.
// Flow:
//   An access is accepted and the table memory is read in that cycle;
//   the held access then merges, writes the entry back and loads the output
//   register once the output register has room. No new access is taken
//   until the held one has fired, so only one access is in flight and no
//   read can see a stale entry.
// Stall: a waiting result holds the output register; an accepted access
//   then waits in the hold stage and the input channel stays stalled.
// Reset: clears the touched marks and all handshake state, and loads the
//   codes with their reset values. The table memory itself is not cleared;
//   an entry is used only when touched.
module resource_barrier_planner_top #(
  parameter int unsigned MAX_RESOURCES = rbp_pkg::DefMaxResources
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rbp_pkg::CfgDataW-1:0] cfg_data,
  // access channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         new_plan,
  input  logic [rbp_pkg::PassW-1:0]    pass_index,
  input  logic [rbp_pkg::ResW-1:0]     resource,
  input  logic                         is_image,
  input  logic                         is_write,
  input  logic [rbp_pkg::StageW-1:0]   stage,
  input  logic [rbp_pkg::AccessW-1:0]  access_flags,
  input  logic [rbp_pkg::LayoutW-1:0]  layout,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         barrier_valid,
  output logic [rbp_pkg::PassW-1:0]    barrier_pass,
  output logic [rbp_pkg::ResW-1:0]     barrier_resource,
  output logic                         barrier_is_image,
  output logic [rbp_pkg::LayoutW-1:0]  src_layout,
  output logic [rbp_pkg::LayoutW-1:0]  dst_layout,
  output logic [rbp_pkg::StageW-1:0]   src_stage,
  output logic [rbp_pkg::AccessW-1:0]  src_access,
  output logic [rbp_pkg::StageW-1:0]   dst_stage,
  output logic [rbp_pkg::AccessW-1:0]  dst_access
);

  localparam int unsigned AW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  // Wide enough for both the resource field and any table index
  localparam int unsigned RW = (AW > rbp_pkg::ResW) ? AW : rbp_pkg::ResW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rbp_pkg::LayoutW-1:0] undef_layout;
  logic [rbp_pkg::StageW-1:0]  top_of_pipe;
  logic [rbp_pkg::AccessW-1:0] no_access;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      undef_layout <= rbp_pkg::UndefLayoutRst;
      top_of_pipe  <= rbp_pkg::TopOfPipeRst;
      no_access    <= rbp_pkg::NoAccessRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbp_pkg::RegUndefLayout: undef_layout <= cfg_data[rbp_pkg::LayoutW-1:0];
        rbp_pkg::RegTopOfPipe:   top_of_pipe  <= cfg_data[rbp_pkg::StageW-1:0];
        rbp_pkg::RegNoAccess:    no_access    <= cfg_data[rbp_pkg::AccessW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input acceptance and the hold stage
  // --------------------------------------------------------------------------
  logic busy;
  logic in_take;
  logic out_free;
  logic fire;

  logic [RW-1:0] res_ext;
  logic          res_in_range;

  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // Resolve the held access once its entry is read and the output has room
  assign fire     = busy && out_free;

  assign res_ext      = RW'(resource);
  // Compare at full parameter width so a power-of-two depth does not wrap
  assign res_in_range = (32'(resource) < MAX_RESOURCES);

  // Held access fields
  logic [rbp_pkg::PassW-1:0]   pass_q;
  logic [rbp_pkg::ResW-1:0]    res_q;
  logic [AW-1:0]               idx_q;
  logic                        in_range_q;
  logic                        img_q;
  logic                        wr_q;
  logic [rbp_pkg::StageW-1:0]  stage_q;
  logic [rbp_pkg::AccessW-1:0] acc_q;
  logic [rbp_pkg::LayoutW-1:0] lay_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_take) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pass_q     <= pass_index;
      res_q      <= resource;
      idx_q      <= res_ext[AW-1:0];
      in_range_q <= res_in_range;
      img_q      <= is_image;
      wr_q       <= is_write;
      stage_q    <= stage;
      acc_q      <= access_flags;
      lay_q      <= layout;
    end
  end

  // --------------------------------------------------------------------------
  // Touched marks: one flop per entry, cleared at once by a new plan
  // --------------------------------------------------------------------------
  logic [MAX_RESOURCES-1:0] touched;

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (in_take && new_plan) begin
      // clear before this access looks up its mark
      touched <= '0;
    end else if (fire && in_range_q) begin
      touched[idx_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Last-access table: synchronous memory, read on accept, written on fire
  // --------------------------------------------------------------------------
  rbp_pkg::entry_t table_mem [MAX_RESOURCES];
  rbp_pkg::entry_t rd_entry;
  rbp_pkg::entry_t wr_entry;

  assign wr_entry = '{wr: wr_q, stage: stage_q, access: acc_q, layout: lay_q};

  always_ff @(posedge clk) begin
    if (in_take && res_in_range) begin
      rd_entry <= table_mem[res_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_range_q) begin
      table_mem[idx_q] <= wr_entry;
    end
  end

  // --------------------------------------------------------------------------
  // Barrier decision
  // --------------------------------------------------------------------------
  logic was_touched;
  logic hazard;
  logic first_write;
  logic bar;

  assign was_touched = in_range_q && touched[idx_q];
  // Previous or current access writes: order must be kept
  assign hazard      = was_touched && (rd_entry.wr || wr_q);
  // First write to an untouched image: transition out of undefined layout
  assign first_write = in_range_q && !was_touched && wr_q && img_q;
  assign bar         = hazard || first_write;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      barrier_valid    <= bar;
      barrier_pass     <= bar ? pass_q : '0;
      barrier_resource <= bar ? res_q : '0;
      barrier_is_image <= bar && img_q;
      dst_layout       <= bar ? lay_q : '0;
      dst_stage        <= bar ? stage_q : '0;
      dst_access       <= bar ? acc_q : '0;
      if (hazard) begin
        src_layout <= rd_entry.layout;
        src_stage  <= rd_entry.stage;
        src_access <= rd_entry.access;
      end else if (first_write) begin
        src_layout <= undef_layout;
        src_stage  <= top_of_pipe;
        src_access <= no_access;
      end else begin
        src_layout <= '0;
        src_stage  <= '0;
        src_access <= '0;
      end
    end
  end

endmodule

// File: sv/rbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_checker: port-level checks of the resource barrier planner
// Watches the handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module rbp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         barrier_valid,
  input logic [rbp_pkg::PassW-1:0]    barrier_pass,
  input logic [rbp_pkg::ResW-1:0]     barrier_resource,
  input logic                         barrier_is_image,
  input logic [rbp_pkg::LayoutW-1:0]  src_layout,
  input logic [rbp_pkg::LayoutW-1:0]  dst_layout,
  input logic [rbp_pkg::StageW-1:0]   src_stage,
  input logic [rbp_pkg::AccessW-1:0]  src_access,
  input logic [rbp_pkg::StageW-1:0]   dst_stage,
  input logic [rbp_pkg::AccessW-1:0]  dst_access
);

  // A stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its decision
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(barrier_valid) && $stable(src_access))
    else $error("stalled result beat changed");

  // One access in flight: an accepted beat stalls the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an access is in flight");

  // A no-barrier result carries all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !barrier_valid |->
      barrier_pass == '0 && barrier_resource == '0 && !barrier_is_image &&
      src_layout == '0 && dst_layout == '0 && src_stage == '0 &&
      src_access == '0 && dst_stage == '0 && dst_access == '0)
    else $error("no-barrier result has nonzero fields");

endmodule

bind resource_barrier_planner_top rbp_checker u_rbp_checker (.*);
